[rtl/sfs_pkg.sv]
// Package for the sprite frame sequencer: command and end-mode codes and
// the default sizes. It depends on nothing else.
package sfs_pkg;

  // Default sizes for the top-level parameters.
  localparam int CLIP_SLOTS_DEF = 8;
  localparam int FRAME_BITS_DEF = 16;

  // Widths of the stream fields.
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 3;
  localparam int FIELD_FRAME_W = 16;
  localparam int MODE_W  = 2;
  localparam int TIME_W  = 32;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 24;

  // Commands carried in the input tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_DEFINE = 2'd0,
    CMD_SELECT = 2'd1,
    CMD_DRAW   = 2'd2
  } cmd_t;

  // End-of-clip behavior. Any other code plays as a loop.
  typedef enum logic [MODE_W-1:0] {
    MODE_LOOP = 2'd0,
    MODE_KEEP = 2'd1,
    MODE_HIDE = 2'd2
  } mode_t;

endpackage

[rtl/sfs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Holds the clip table of the sprite frame sequencer; no dependencies.
module sfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read in the same cycle as a
  // write to that address returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/sprite_frame_sequencer.sv]
// Top level of the sprite frame sequencer: command decode, clip playback
// state and the result register. Depends on sfs_pkg and sfs_ram.
//
//  channel | direction | tuser          | tdata                          | result
//  --------+-----------+----------------+--------------------------------+---------------
//  in_     | slave     | command        | index, bounds, mode, time, now | none
//  out_    | master    | -              | visible, frame_index           | one per draw
//
// Each command passes through the input register; a draw result then sits
// in the output register until taken. One transaction is accepted per
// cycle while no draw waits on a full result register, set by the single
// pass through the clip state between the input and result registers.
// Reset clears the playback state; the clip table holds garbage until
// defined. A stalled result holds a pending draw in the input register
// and drops in_tready; defines and selects never wait.
module sprite_frame_sequencer #(
  parameter int CLIP_SLOTS = sfs_pkg::CLIP_SLOTS_DEF,
  parameter int FRAME_BITS = sfs_pkg::FRAME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Fields from bit 0: entry_index[2:0], start_frame[18:3], end_frame[34:19],
  // end_mode[36:35], frame_time[68:37], now_ms[100:69], zero fill to 103.
  input  logic [sfs_pkg::IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0: command[1:0].
  input  logic [sfs_pkg::CMD_W-1:0]      in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // Fields from bit 0: visible[0], frame_index[16:1], zero fill to 23.
  output logic [sfs_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int FW      = FRAME_BITS;
  localparam int ADDR_W  = (CLIP_SLOTS > 1) ? $clog2(CLIP_SLOTS) : 1;
  localparam int ENTRY_W = 2 * FW + sfs_pkg::MODE_W + sfs_pkg::TIME_W;
  localparam int IDX_CMP_W = 9;
  localparam logic [IDX_CMP_W-1:0] SLOTS = IDX_CMP_W'(CLIP_SLOTS);

  // Input field unpacking.
  logic [sfs_pkg::INDEX_W-1:0]       in_index;
  logic [sfs_pkg::FIELD_FRAME_W-1:0] in_start;
  logic [sfs_pkg::FIELD_FRAME_W-1:0] in_end;
  logic [sfs_pkg::MODE_W-1:0]        in_mode;
  logic [sfs_pkg::TIME_W-1:0]        in_ftime;
  logic [sfs_pkg::TIME_W-1:0]        in_now;
  logic                              in_accept;
  logic                              in_index_ok;
  logic [IDX_CMP_W-1:0]              in_index_ext;

  assign in_index = in_tdata[2:0];
  assign in_start = in_tdata[18:3];
  assign in_end   = in_tdata[34:19];
  assign in_mode  = in_tdata[36:35];
  assign in_ftime = in_tdata[68:37];
  assign in_now   = in_tdata[100:69];

  assign in_accept    = in_tvalid && in_tready;
  assign in_index_ext = IDX_CMP_W'(in_index);
  assign in_index_ok  = in_index_ext < SLOTS;

  // Clip table. A define is written on acceptance; a select reads its entry
  // on acceptance and finds the data ready when it reaches the pass stage.
  logic               ram_wr_en;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic [ENTRY_W-1:0] ram_rd_data;
  logic [ADDR_W-1:0]  ram_addr;

  assign ram_addr    = in_index_ext[ADDR_W-1:0];
  assign ram_wr_en   = in_accept && (sfs_pkg::cmd_t'(in_tuser) == sfs_pkg::CMD_DEFINE)
                       && in_index_ok;
  assign ram_wr_data = {in_ftime, in_mode, FW'(in_end), FW'(in_start)};

  sfs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CLIP_SLOTS)
  ) u_clip_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_addr),
    .rd_data (ram_rd_data)
  );

  // Input register.
  logic                              s1_valid_r;
  sfs_pkg::cmd_t                     s1_cmd_r;
  logic [sfs_pkg::INDEX_W-1:0]       s1_index_r;
  logic                              s1_index_ok_r;
  logic [FW-1:0]                     s1_start_r;
  logic [FW-1:0]                     s1_end_r;
  logic [sfs_pkg::MODE_W-1:0]        s1_mode_r;
  logic [sfs_pkg::TIME_W-1:0]        s1_ftime_r;
  logic [sfs_pkg::TIME_W-1:0]        s1_now_r;
  logic                              s1_go;
  logic                              s1_is_draw;

  // Playback state and a copy of the current clip's entry.
  logic                              sel_r,   sel_nxt;
  logic [sfs_pkg::INDEX_W-1:0]       clip_r,  clip_nxt;
  logic [FW-1:0]                     frame_r, frame_nxt;
  logic                              ended_r, ended_nxt;
  logic [sfs_pkg::TIME_W-1:0]        fst_r,   fst_nxt;
  logic [FW-1:0]                     cur_start_r, cur_start_nxt;
  logic [FW-1:0]                     cur_end_r,   cur_end_nxt;
  logic [sfs_pkg::MODE_W-1:0]        cur_mode_r,  cur_mode_nxt;
  logic [sfs_pkg::TIME_W-1:0]        cur_time_r,  cur_time_nxt;

  // Result register.
  logic                              out_valid_r;
  logic                              out_vis_r,   out_vis_nxt;
  logic [sfs_pkg::FIELD_FRAME_W-1:0] out_frame_r, out_frame_nxt;

  // Flow control: only a draw can wait, and only on a full result register.
  assign s1_is_draw = (s1_cmd_r == sfs_pkg::CMD_DRAW);
  assign s1_go      = s1_valid_r && (!s1_is_draw || !out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r      <= sfs_pkg::cmd_t'(in_tuser);
      s1_index_r    <= in_index;
      s1_index_ok_r <= in_index_ok;
      s1_start_r    <= FW'(in_start);
      s1_end_r      <= FW'(in_end);
      s1_mode_r     <= in_mode;
      s1_ftime_r    <= in_ftime;
      s1_now_r      <= in_now;
    end
  end

  // Single pass over the command in the input register.
  logic [FW:0]               next_frame;
  logic [sfs_pkg::TIME_W-1:0] elapsed;
  logic                      cur_is_keep;

  assign next_frame  = {1'b0, frame_r} + {{FW{1'b0}}, 1'b1};
  assign elapsed     = s1_now_r - fst_r;
  assign cur_is_keep = (sfs_pkg::mode_t'(cur_mode_r) == sfs_pkg::MODE_KEEP);

  always_comb begin
    sel_nxt       = sel_r;
    clip_nxt      = clip_r;
    frame_nxt     = frame_r;
    ended_nxt     = ended_r;
    fst_nxt       = fst_r;
    cur_start_nxt = cur_start_r;
    cur_end_nxt   = cur_end_r;
    cur_mode_nxt  = cur_mode_r;
    cur_time_nxt  = cur_time_r;
    out_vis_nxt   = 1'b0;
    out_frame_nxt = '0;

    if (s1_go) begin
      unique case (s1_cmd_r)
        sfs_pkg::CMD_DEFINE: begin
          // A redefined current clip takes effect without a restart.
          if (s1_index_ok_r && (s1_index_r == clip_r)) begin
            cur_start_nxt = s1_start_r;
            cur_end_nxt   = s1_end_r;
            cur_mode_nxt  = s1_mode_r;
            cur_time_nxt  = s1_ftime_r;
          end
        end
        sfs_pkg::CMD_SELECT: begin
          if (s1_index_ok_r && (!sel_r || (s1_index_r != clip_r))) begin
            sel_nxt       = 1'b1;
            clip_nxt      = s1_index_r;
            frame_nxt     = ram_rd_data[FW-1:0];
            ended_nxt     = 1'b0;
            fst_nxt       = s1_now_r;
            cur_start_nxt = ram_rd_data[FW-1:0];
            cur_end_nxt   = ram_rd_data[2*FW-1:FW];
            cur_mode_nxt  = ram_rd_data[2*FW+sfs_pkg::MODE_W-1:2*FW];
            cur_time_nxt  = ram_rd_data[ENTRY_W-1:2*FW+sfs_pkg::MODE_W];
          end
        end
        sfs_pkg::CMD_DRAW: begin
          if (sel_r && ended_r) begin
            // Only a kept clip still shows its last frame.
            out_vis_nxt   = cur_is_keep;
            out_frame_nxt = cur_is_keep ? 16'(frame_r) : '0;
          end else if (sel_r) begin
            out_vis_nxt   = 1'b1;
            out_frame_nxt = 16'(frame_r);
            if (elapsed > cur_time_r) begin
              fst_nxt = s1_now_r;
              if (next_frame >= {1'b0, cur_end_r}) begin
                priority case (sfs_pkg::mode_t'(cur_mode_r))
                  sfs_pkg::MODE_KEEP: ended_nxt = 1'b1;
                  sfs_pkg::MODE_HIDE: begin
                    frame_nxt = next_frame[FW-1:0];
                    ended_nxt = 1'b1;
                  end
                  default: frame_nxt = cur_start_r;
                endcase
              end else begin
                frame_nxt = next_frame[FW-1:0];
              end
            end
          end
        end
        default: begin
          // Unused command code: no effect, no result.
        end
      endcase
    end
  end

  // Playback state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= 1'b0;
      clip_r  <= '0;
      frame_r <= '0;
      ended_r <= 1'b0;
      fst_r   <= '0;
    end else begin
      sel_r   <= sel_nxt;
      clip_r  <= clip_nxt;
      frame_r <= frame_nxt;
      ended_r <= ended_nxt;
      fst_r   <= fst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_start_r <= cur_start_nxt;
    cur_end_r   <= cur_end_nxt;
    cur_mode_r  <= cur_mode_nxt;
    cur_time_r  <= cur_time_nxt;
  end

  // Result register: loaded by a draw, emptied by the output transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_is_draw) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_is_draw) begin
      out_vis_r   <= out_vis_nxt;
      out_frame_r <= out_frame_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_frame_r, out_vis_r};

endmodule
